@@ sv/lvp_pkg.sv @@
`default_nettype none

package lvp_pkg;

   // table geometry
   localparam int unsigned DEFAULT_TABLE_ENTRIES = 1024;

   // operation codes
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_UPDATE = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // register indexes (byte address / 4)
   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_SHIFT     = 1'b1;

   // register reset values
   localparam logic [7:0] THRESHOLD_RESET = 8'd250;
   localparam logic [2:0] SHIFT_RESET     = 3'd2;

   // fixed constants
   localparam logic [7:0] CONF_MAX  = 8'd255;
   localparam logic [3:0] SKIP_SIZE = 4'd8;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] pc;
      logic [63:0] actual_value;
      logic [3:0]  data_size;
   } req_type;

   typedef struct packed {
      logic        prediction_valid;
      logic [63:0] predicted_value;
      logic        mispredicted;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] tag;
      logic [63:0] value;
      logic [7:0]  confidence;
   } entry_type;

endpackage

`default_nettype wire

@@ sv/load_value_predictor.sv @@
`default_nettype none

// Last-value load value predictor with a saturating confidence counter per entry.
// The table is a direct-mapped single-port RAM with a registered read.
// It is indexed by (pc >> index_shift) masked with TABLE_ENTRIES-1 and tagged with the
// full pc. In the accept cycle of a beat the entry is read into a register. In the
// evaluation state, once the output register can take the result, the entry is checked,
// the result is loaded into the output register and any update is written back. A new
// beat is accepted only after the last has finished, since the one RAM port is read and
// then written for each beat. A held result only stalls the block when a second result
// is ready to leave. After reset, and after every clear beat, the block sweeps the RAM,
// one entry a cycle, to drop the valid bits. During the sweep req_ready is low. The
// result of a clear beat is loaded into the output register as the sweep starts.
// Configuration writes are taken at any time but should be made only while the block
// is idle. The two registers are threshold at byte address 0 and index shift at
// byte address 4.
module load_value_predictor #(
   parameter int unsigned TABLE_ENTRIES = lvp_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire lvp_pkg::req_type req_data,
   // result channel
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      lvp_pkg::rsp_type rsp_data,
   // configuration port
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [2:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output      logic [31:0]      prdata,
   output      logic             pready
);

   import lvp_pkg::*;

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

   // sequencer states
   localparam logic [1:0] ST_SWEEP = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [7:0] threshold_ff;
   logic [2:0] shift_ff;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         shift_ff     <= SHIFT_RESET;
      end else if (csr_write) begin
         // addresses beyond the two registers fold onto paddr[2]; low bits ignored
         if (paddr[2] == REG_THRESHOLD) begin
            threshold_ff <= pwdata[7:0];
         end else begin
            shift_ff <= pwdata[2:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_SHIFT) begin
         prdata = {29'd0, shift_ff};
      end else begin
         prdata = {24'd0, threshold_ff};
      end
   end

   // ---------------------------------------------------------------
   // control and beat registers
   // ---------------------------------------------------------------
   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   req_type          item_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             req_accept;
   logic [63:0]      pc_shifted;
   logic [IDX_W-1:0] req_idx;
   logic             eval_done;

   // table index from the incoming pc
   assign pc_shifted = req_data.pc >> shift_ff;
   assign req_idx    = pc_shifted[IDX_W-1:0] & IDX_MASK;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid & req_ready;

   // evaluation finishes once the output register can take the result
   assign eval_done  = (state_ff == ST_EVAL) & (~rsp_valid_ff | rsp_ready);

   // ---------------------------------------------------------------
   // table memory
   // ---------------------------------------------------------------
   entry_type        mem [TABLE_ENTRIES];
   entry_type        rd_entry_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wr_idx;
   entry_type        mem_wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wr_idx] <= mem_wr_data;
      end
      if (req_accept) begin
         rd_entry_ff <= mem[req_idx];
      end
   end

   // ---------------------------------------------------------------
   // entry check and update
   // ---------------------------------------------------------------
   logic      hit;
   logic      confident;
   logic      same_value;
   logic      do_update;
   entry_type upd_entry;
   rsp_type   result;

   assign hit        = rd_entry_ff.valid & (rd_entry_ff.tag == item_ff.pc);
   assign confident  = (rd_entry_ff.confidence >= threshold_ff);
   assign same_value = (rd_entry_ff.value == item_ff.actual_value);
   assign do_update  = (item_ff.op == OP_UPDATE) & (item_ff.data_size != SKIP_SIZE);

   always_comb begin
      result    = '0;
      upd_entry = rd_entry_ff;
      case (item_ff.op)
         OP_LOOKUP: begin
            if (hit & confident) begin
               result.prediction_valid = 1'b1;
               result.predicted_value  = rd_entry_ff.value;
            end
         end
         OP_UPDATE: begin
            if (!hit) begin
               // allocate the entry afresh
               upd_entry.valid      = 1'b1;
               upd_entry.tag        = item_ff.pc;
               upd_entry.value      = item_ff.actual_value;
               upd_entry.confidence = 8'd1;
            end else if (same_value) begin
               if (rd_entry_ff.confidence != CONF_MAX) begin
                  upd_entry.confidence = rd_entry_ff.confidence + 8'd1;
               end
            end else begin
               // value changed: squash if the entry was trusted and data_size is not SKIP_SIZE
               result.mispredicted  = (item_ff.data_size != SKIP_SIZE) & confident;
               upd_entry.value      = item_ff.actual_value;
               upd_entry.confidence = 8'd0;
            end
         end
         default: begin
            // clear and the unused code give an all-zero result
         end
      endcase
   end

   // write port: sweep clears valid bits, evaluation writes the update back
   always_comb begin
      mem_we      = 1'b0;
      mem_wr_idx  = sweep_ff;
      mem_wr_data = '0;
      if (state_ff == ST_SWEEP) begin
         mem_we = 1'b1;
      end else if (eval_done & do_update) begin
         mem_we      = 1'b1;
         mem_wr_idx  = idx_ff;
         mem_wr_data = upd_entry;
      end
   end

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_SWEEP: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == IDX_LAST) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (eval_done) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               state_in     = (item_ff.op == OP_CLEAR) ? ST_SWEEP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_accept) begin
         item_ff <= req_data;
         idx_ff  <= req_idx;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // an accepted beat always enters the evaluation state in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_EVAL))
      else $error("accepted beat not evaluated");

   // the table is written only by the sweep or by a finishing update
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_SWEEP) || (eval_done && do_update)))
      else $error("stray table write");

   // a result never carries both a prediction and a squash
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.prediction_valid && rsp_data_ff.mispredicted))
      else $error("prediction and squash in one result");

   // leaving reset always starts the clearing sweep from the first entry
   assert property (@(posedge clock)
      $fell(reset) |-> ((state_ff == ST_SWEEP) && (sweep_ff == '0)))
      else $error("no sweep after reset");

   // a finished clear beat always starts a fresh sweep
   assert property (@(posedge clock) disable iff (reset)
      (eval_done && (item_ff.op == OP_CLEAR)) |=> ((state_ff == ST_SWEEP) && (sweep_ff == '0)))
      else $error("clear beat did not start a sweep");

endmodule

`default_nettype wire
